### rtl/ssbac_pkg.sv
// Shared types and constants for the shared serial bus access controller.
// No dependencies; used by every module under rtl/.
`default_nettype none

package ssbac_pkg;

  // bus modes
  localparam logic [2:0] MODE_CONNECTING = 3'd0;
  localparam logic [2:0] MODE_IDLE       = 3'd1;
  localparam logic [2:0] MODE_RECEIVING  = 3'd2;
  localparam logic [2:0] MODE_SENDING    = 3'd3;
  localparam logic [2:0] MODE_COLLISION  = 3'd4;
  localparam logic [2:0] MODE_FAIRWAIT   = 3'd5;

  // request codes
  localparam logic [2:0] FUNC_POLL    = 3'd0;
  localparam logic [2:0] FUNC_RX_BYTE = 3'd1;
  localparam logic [2:0] FUNC_START   = 3'd2;
  localparam logic [2:0] FUNC_TX_BYTE = 3'd3;
  localparam logic [2:0] FUNC_PREWAIT = 3'd4;
  localparam logic [2:0] FUNC_INIT    = 3'd5;

  // events
  localparam logic [2:0] EV_NONE       = 3'd0;
  localparam logic [2:0] EV_RX_START   = 3'd1;
  localparam logic [2:0] EV_RX_END     = 3'd2;
  localparam logic [2:0] EV_TX_START   = 3'd3;
  localparam logic [2:0] EV_TX_END     = 3'd4;
  localparam logic [2:0] EV_COLL_START = 3'd5;
  localparam logic [2:0] EV_COLL_END   = 3'd6;

  // byte kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_RX   = 2'd1;
  localparam logic [1:0] KIND_TX   = 2'd2;

  // replies
  localparam logic [1:0] REPLY_OK          = 2'd0;
  localparam logic [1:0] REPLY_BUSY        = 2'd1;
  localparam logic [1:0] REPLY_ECHO_PEND   = 2'd2;
  localparam logic [1:0] REPLY_NOT_SENDING = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_BYTE_TIME   = 3'd0;
  localparam logic [2:0] CFG_PKT_TIMEOUT = 3'd1;
  localparam logic [2:0] CFG_FW_EXTRA    = 3'd2;
  localparam logic [2:0] CFG_ECHO_EN     = 3'd3;
  localparam logic [2:0] CFG_DROP_COLL   = 3'd4;

  localparam logic [15:0] BYTE_TIME_RST   = 16'd1041;
  localparam logic [7:0]  PKT_TIMEOUT_RST = 8'd3;

  localparam logic [8:0] NOTHING_PENDING = 9'h1FF;

  localparam int MAX_RES    = 3;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  // all results caused by one request
  typedef struct packed {
    logic [1:0]                cnt;   // 1 .. MAX_RES
    logic [MAX_RES-1:0][2:0]   ev;
    logic [MAX_RES-1:0][1:0]   kind;
    logic [MAX_RES-1:0][8:0]   val;
    logic [1:0]                reply;
    logic [2:0]                mode;
  } ssbac_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ssbac_fifo_stat_t;

endpackage

`default_nettype wire

### rtl/shared_serial_bus_access_control_top.sv
// Top level of the shared serial bus access controller.
// Depends on ssbac_pkg, ssbac_front, ssbac_fifo, ssbac_back.
`default_nettype none

// Media access control for a single-wire shared bus where each station hears
// its own transmissions. Each input transfer is one timed request (poll,
// received byte, start send, transmit byte, prewait, init) carrying the
// current 32-bit time; it produces one to three result transfers (events,
// delivered or transmitted bytes), the last marked by tlast, all carrying the
// reply code and the bus mode after the request. The front end decides a
// request in the cycle it is accepted (timeout is byte_time times a
// multiplier compared against wrapped elapsed time), so a new request can be
// accepted every cycle while the queue is not full. Its result list goes into
// a four-entry queue; the back end drains it through an output register at
// one result per cycle unless m_axis_tready holds it. Sustained rate (output
// ready): one request per cycle when each yields one result; a request
// yielding several results occupies the output one result at a time, and
// input is held off only once the queue is full. Config writes are always
// accepted (cfg_ready_o is high) and must only happen while no request is in
// flight; unknown indexes are ignored.
module shared_serial_bus_access_control_top
  import ssbac_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // request stream
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // now[31:0], value[40:32], rand_pick[42:41]
  input  wire logic [2:0]  s_axis_tuser,  // func[2:0]
  // result stream
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [23:0] m_axis_tdata,  // event_res[2:0], byte_value[11:3],
                                          // reply[13:12], bus_state[16:14]
  output      logic [1:0]  m_axis_tuser,  // byte_kind[1:0]
  output      logic        m_axis_tlast   // last
);

  ssbac_entry_t     push_entry;
  ssbac_entry_t     head;
  ssbac_fifo_stat_t fifo_stat;
  logic             push;
  logic             pop;

  logic [2:0] out_ev;
  logic [8:0] out_val;
  logic [1:0] out_reply;
  logic [2:0] out_mode;

  assign cfg_ready_o = 1'b1;

  ssbac_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (s_axis_tvalid),
    .item_ready_o (s_axis_tready),
    .item_func_i  (s_axis_tuser),
    .item_now_i   (s_axis_tdata[31:0]),
    .item_value_i (s_axis_tdata[40:32]),
    .item_rand_i  (s_axis_tdata[42:41]),
    .stat_i       (fifo_stat),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  ssbac_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (fifo_stat)
  );

  ssbac_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .stat_i      (fifo_stat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_ev_o    (out_ev),
    .out_kind_o  (m_axis_tuser),
    .out_val_o   (out_val),
    .out_reply_o (out_reply),
    .out_mode_o  (out_mode),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, out_mode, out_reply, out_val, out_ev};

  // an accepted request is visible in the queue on the next cycle
  a_push_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> !fifo_stat.empty)
    else $error("accepted request not queued");

  // queue never pushed while full
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_stat.full |-> !push)
    else $error("queue overflow");

  // a transmitted byte only comes with an ok reply
  a_tx_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_TX) |-> out_reply == REPLY_OK)
    else $error("transmit byte with error reply");

  // pop only at the last result of a list
  a_pop_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> m_axis_tlast)
    else $error("queue entry dropped before its last result");

endmodule

`default_nettype wire

### rtl/ssbac_front.sv
// Front end: config registers, bus mode state machine, result list build.
// Depends on ssbac_pkg.
`default_nettype none

module ssbac_front
  import ssbac_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_valid_i,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [15:0]  cfg_data_i,
  input  wire logic         item_valid_i,
  output      logic         item_ready_o,
  input  wire logic [2:0]   item_func_i,
  input  wire logic [31:0]  item_now_i,
  input  wire logic [8:0]   item_value_i,
  input  wire logic [1:0]   item_rand_i,
  input  wire ssbac_fifo_stat_t stat_i,
  output      logic         push_o,
  output      ssbac_entry_t entry_o
);

  logic [15:0] byte_time_q;
  logic [7:0]  pkt_to_q;
  logic [1:0]  fw_extra_q;
  logic        echo_en_q;
  logic        drop_coll_q;

  logic [2:0]  mode_q, mode_d;
  logic [31:0] last_act_q, last_act_d;
  logic [8:0]  echo_q, echo_d;

  logic [7:0]  mul;
  logic [23:0] limit;
  logic [31:0] elapsed;
  logic        timed_out;
  logic [2:0]  fw_base;
  logic [1:0]  rnd_mod;
  logic [2:0]  fw_rx;
  logic        accept;

  assign item_ready_o = !stat_i.full;
  assign accept       = item_valid_i && item_ready_o;
  assign push_o       = accept;

  assign mul       = (mode_q == MODE_FAIRWAIT) ? echo_q[7:0] : pkt_to_q;
  assign limit     = {8'd0, byte_time_q} * {16'd0, mul};
  assign elapsed   = item_now_i - last_act_q;
  assign timed_out = elapsed >= {8'd0, limit};
  assign fw_base   = {1'b0, fw_extra_q} + 3'd1;
  assign rnd_mod   = (item_rand_i == 2'd3) ? 2'd0 : item_rand_i;
  assign fw_rx     = fw_base + {1'b0, rnd_mod};

  always_comb begin
    logic [1:0] n;
    n          = 2'd0;
    mode_d     = mode_q;
    last_act_d = last_act_q;
    echo_d     = echo_q;
    entry_o    = '0;
    entry_o.reply = REPLY_OK;
    case (item_func_i)
      FUNC_POLL: begin
        if (mode_q != MODE_IDLE && timed_out) begin
          case (mode_q)
            MODE_FAIRWAIT: begin
              mode_d     = MODE_IDLE;
              last_act_d = item_now_i;
            end
            MODE_RECEIVING: begin
              echo_d       = {6'd0, fw_rx};
              mode_d       = MODE_FAIRWAIT;
              last_act_d   = item_now_i;
              entry_o.ev[n] = EV_RX_END;
              n            = n + 2'd1;
            end
            MODE_SENDING: begin
              echo_d       = {6'd0, fw_base};
              mode_d       = MODE_FAIRWAIT;
              last_act_d   = item_now_i;
              entry_o.ev[n] = EV_TX_END;
              n            = n + 2'd1;
            end
            MODE_COLLISION: begin
              echo_d       = {6'd0, fw_base};
              mode_d       = MODE_FAIRWAIT;
              last_act_d   = item_now_i;
              entry_o.ev[n] = EV_COLL_END;
              n            = n + 2'd1;
            end
            default: begin
              mode_d = MODE_IDLE;   // connecting: line found quiet
            end
          endcase
        end
      end
      FUNC_RX_BYTE: begin
        if (mode_q == MODE_SENDING || mode_q == MODE_COLLISION) begin
          // own echo expected
          if (echo_en_q) begin
            if (item_value_i[8] || echo_q != item_value_i) begin
              mode_d = MODE_COLLISION;
              if (mode_q != MODE_COLLISION) begin
                entry_o.ev[n] = EV_COLL_START;
                n = n + 2'd1;
              end
              if (mode_q == MODE_SENDING) begin
                entry_o.ev[n] = EV_TX_END;
                n = n + 2'd1;
              end
              if (!drop_coll_q) begin
                entry_o.kind[n] = KIND_RX;
                entry_o.val[n]  = item_value_i;
                n = n + 2'd1;
              end
            end else begin
              echo_d = NOTHING_PENDING;
            end
          end
          last_act_d = item_now_i;
        end else begin
          if (mode_q == MODE_IDLE || mode_q == MODE_FAIRWAIT) begin
            mode_d        = MODE_RECEIVING;
            last_act_d    = item_now_i;
            entry_o.ev[n] = EV_RX_START;
            n             = n + 2'd1;
          end else if (mode_q == MODE_RECEIVING) begin
            last_act_d = item_now_i;
          end
          entry_o.kind[n] = KIND_RX;
          entry_o.val[n]  = item_value_i;
          n = n + 2'd1;
        end
      end
      FUNC_START: begin
        if (mode_q != MODE_IDLE) begin
          entry_o.reply = REPLY_BUSY;
        end else begin
          mode_d        = MODE_SENDING;
          last_act_d    = item_now_i;
          echo_d        = NOTHING_PENDING;
          entry_o.ev[n] = EV_TX_START;
          n             = n + 2'd1;
        end
      end
      FUNC_TX_BYTE: begin
        if (echo_en_q && mode_q != MODE_SENDING) begin
          entry_o.reply = REPLY_NOT_SENDING;
        end else if (echo_en_q && echo_q != NOTHING_PENDING) begin
          entry_o.reply = REPLY_ECHO_PEND;
        end else begin
          echo_d          = {1'b0, item_value_i[7:0]};
          entry_o.kind[n] = KIND_TX;
          entry_o.val[n]  = {1'b0, item_value_i[7:0]};
          n = n + 2'd1;
        end
      end
      FUNC_PREWAIT: begin
        if (mode_q == MODE_IDLE || mode_q == MODE_FAIRWAIT) begin
          echo_d = {1'b0, item_value_i[7:0]};
          mode_d = MODE_FAIRWAIT;
        end
      end
      FUNC_INIT: begin
        mode_d     = MODE_CONNECTING;
        last_act_d = item_now_i;
      end
      default: begin
      end
    endcase
    // no action still yields one empty result (slot 0 is all zero)
    if (n == 2'd0) begin
      n = 2'd1;
    end
    entry_o.cnt  = n;
    entry_o.mode = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_time_q <= BYTE_TIME_RST;
      pkt_to_q    <= PKT_TIMEOUT_RST;
      fw_extra_q  <= 2'd0;
      echo_en_q   <= 1'b1;
      drop_coll_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BYTE_TIME:   byte_time_q <= cfg_data_i;
        CFG_PKT_TIMEOUT: pkt_to_q    <= cfg_data_i[7:0];
        CFG_FW_EXTRA:    fw_extra_q  <= cfg_data_i[1:0];
        CFG_ECHO_EN:     echo_en_q   <= cfg_data_i[0];
        CFG_DROP_COLL:   drop_coll_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_CONNECTING;
      last_act_q <= 32'd0;
      echo_q     <= NOTHING_PENDING;
    end else if (accept) begin
      mode_q     <= mode_d;
      last_act_q <= last_act_d;
      echo_q     <= echo_d;
    end
  end

endmodule

`default_nettype wire

### rtl/ssbac_fifo.sv
// Small queue of per-request result lists between front and back end.
// Depends on ssbac_pkg.
`default_nettype none

module ssbac_fifo
  import ssbac_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire ssbac_entry_t entry_i,
  input  wire logic         pop_i,
  output      ssbac_entry_t head_o,
  output      ssbac_fifo_stat_t stat_o
);

  ssbac_entry_t         mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]     count_q;

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = count_q == (FIFO_AW+1)'(FIFO_DEPTH);
  assign stat_o.empty = count_q == '0;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + (FIFO_AW+1)'(1);
        2'b01:   count_q <= count_q - (FIFO_AW+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/ssbac_back.sv
// Back end: walks the result list at the queue head, one result per cycle
// unless out_ready_i holds it, into the output register. Depends on ssbac_pkg.
`default_nettype none

module ssbac_back
  import ssbac_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire ssbac_entry_t head_i,
  input  wire ssbac_fifo_stat_t stat_i,
  output      logic         pop_o,
  output      logic         out_valid_o,
  input  wire logic         out_ready_i,
  output      logic [2:0]   out_ev_o,
  output      logic [1:0]   out_kind_o,
  output      logic [8:0]   out_val_o,
  output      logic [1:0]   out_reply_o,
  output      logic [2:0]   out_mode_o,
  output      logic         out_last_o
);

  logic [1:0] slot_q;
  logic       valid_q;
  logic       load;
  logic       last_slot;

  assign load      = !stat_i.empty && (!valid_q || out_ready_i);
  assign last_slot = slot_q == (head_i.cnt - 2'd1);
  assign pop_o     = load && last_slot;

  assign out_valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      slot_q  <= 2'd0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        slot_q  <= last_slot ? 2'd0 : slot_q + 2'd1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_ev_o    <= head_i.ev[slot_q];
      out_kind_o  <= head_i.kind[slot_q];
      out_val_o   <= head_i.val[slot_q];
      out_reply_o <= head_i.reply;
      out_mode_o  <= head_i.mode;
      out_last_o  <= last_slot;
    end
  end

endmodule

`default_nettype wire
